@@ design/pl0se_pkg.sv @@
// ----------------------------------------------------------------------------
// pl0se_pkg
// Shared types, codes and constants of the PL/0 p-code executor.
// ----------------------------------------------------------------------------
package pl0se_pkg;

  localparam int STACK_DEPTH = 1024;
  localparam int STACK_AW    = 10;
  localparam int CODE_AW     = 10;
  localparam int DATA_W      = 32;
  localparam int LEVEL_W     = 6;
  localparam int MAX_LEVEL   = 32;

  localparam logic [4:0] PREV_NONE = 5'd16;

  localparam logic [DATA_W-1:0] OPR_RET = 32'd0;
  localparam logic [DATA_W-1:0] OPR_NEG = 32'd1;
  localparam logic [DATA_W-1:0] OPR_ADD = 32'd2;
  localparam logic [DATA_W-1:0] OPR_SUB = 32'd3;
  localparam logic [DATA_W-1:0] OPR_MUL = 32'd4;
  localparam logic [DATA_W-1:0] OPR_DIV = 32'd5;
  localparam logic [DATA_W-1:0] OPR_ODD = 32'd6;
  localparam logic [DATA_W-1:0] OPR_EQ  = 32'd7;
  localparam logic [DATA_W-1:0] OPR_NE  = 32'd8;
  localparam logic [DATA_W-1:0] OPR_LT  = 32'd9;
  localparam logic [DATA_W-1:0] OPR_GE  = 32'd10;
  localparam logic [DATA_W-1:0] OPR_GT  = 32'd11;
  localparam logic [DATA_W-1:0] OPR_LE  = 32'd12;

  typedef enum logic [3:0] {
    OP_LIT, OP_OPR, OP_LOD, OP_STO, OP_CAL, OP_INT, OP_JMP, OP_JPC,
    OP_LEA, OP_LODA, OP_STOA, OP_READDR, OP_ADDR_ADD, OP_ADDR_MIN,
    OP_PRINT, OP_NEWLINE
  } opcode_e;

  typedef enum logic [1:0] {
    ERR_NONE, ERR_DIV0, ERR_READDR, ERR_RANGE
  } err_e;

  typedef struct packed {
    logic [3:0]          opcode;
    logic [LEVEL_W-1:0]  level_diff;
    logic signed [31:0]  operand;
  } instr_t;

  typedef struct packed {
    logic [CODE_AW-1:0]  next_pc;
    logic                halted;
    logic                print_valid;
    logic signed [31:0]  print_value;
    logic                newline;
    logic [1:0]          error_code;
  } result_t;

  typedef enum logic [3:0] {
    A_TOP, A_TOP_M1, A_TOP_P1, A_TOP_P2, A_TOP_P3, A_BASE_P1, A_BASE_P2,
    A_B, A_EFF, A_LA, A_RD, A_CLR
  } addr_sel_e;

  typedef enum logic [3:0] {
    W_OPD, W_NEG, W_ODD, W_RDZ, W_A, W_AM, W_B, W_BASE, W_PC, W_LEA,
    W_C, W_LA, W_ZERO
  } wdata_sel_e;

  typedef enum logic [2:0] {
    T_HOLD, T_INC, T_DEC, T_DEC2, T_ADD_OPD, T_BASE_M1
  } top_op_e;

  typedef enum logic [1:0] {
    P_HOLD, P_INC, P_OPD, P_RD
  } pc_op_e;

  typedef enum logic [1:0] {
    LA_HOLD, LA_EFF, LA_RD
  } la_op_e;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_DECODE, S_RET1, S_RET2, S_UN, S_BIN1, S_BIN2,
    S_BIN3, S_DIV_WAIT, S_BIN4, S_STO1, S_WALK, S_WALK_RD, S_WALK_END,
    S_LOD_W, S_CAL2, S_CAL3, S_JPC1, S_LODA1, S_LODA2, S_STOA1, S_STOA2,
    S_STOA3, S_AM1, S_AM2, S_AM3, S_AM4, S_PRT1, S_DONE
  } state_e;

  typedef struct packed {
    logic       mem_en;
    logic       mem_we;
    addr_sel_e  addr_sel;
    wdata_sel_e wdata_sel;
    logic       instr_ld;
    logic       ld_c;
    logic       ld_a_rd;
    logic       ld_a_alu;
    logic       ld_a_div;
    logic       div_start;
    top_op_e    top_op;
    pc_op_e     pc_op;
    logic       base_ld_rd;
    logic       base_ld_call;
    la_op_e     la_op;
    logic       walk_init;
    logic       walk_step;
    logic       walk_fail;
    logic       hit_ld_eff;
    logic       hit_ld_rd;
    logic       err_set;
    err_e       err_val;
    logic       out_ld;
    logic       clr_step;
  } cmd_t;

  typedef struct packed {
    opcode_e op;
    logic    opr_ret;
    logic    opr_neg;
    logic    opr_odd;
    logic    opr_bin;
    logic    opr_div;
    logic    prev_load;
    logic    walk_ok;
    logic    n_zero;
    logic    rd_in;
    logic    rd_zero;
    logic    eff_in;
    logic    la_in;
    logic    hit;
    logic    c_zero;
    logic    div_done;
    logic    clr_done;
    logic    out_free;
  } sts_t;

endpackage

@@ design/pl0se_ram.sv @@
// ----------------------------------------------------------------------------
// pl0se_ram
// Single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module pl0se_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_o <= mem_q[addr_i];
      end
    end
  end

endmodule

@@ design/pl0se_div.sv @@
// ----------------------------------------------------------------------------
// pl0se_div
// Signed 32-bit divider, one quotient bit per cycle, truncating to zero.
// ----------------------------------------------------------------------------
module pl0se_div
  import pl0se_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DATA_W-1:0] dividend_i,
  input  logic [DATA_W-1:0] divisor_i,
  output logic              done_o,
  output logic [DATA_W-1:0] quot_o
);

  localparam int CNT_W = $clog2(DATA_W + 1);

  logic              busy_q, busy_d, done_q, done_d, neg_q, neg_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [DATA_W-1:0] rem_q, rem_d, dvd_q, dvd_d, dvs_q, dvs_d;
  logic [DATA_W:0]   shifted;
  logic [DATA_W:0]   diff;

  assign shifted = {rem_q, dvd_q[DATA_W-1]};
  assign diff    = shifted - {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = done_q;
    neg_d  = neg_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      done_d = 1'b0;
      neg_d  = dividend_i[DATA_W-1] ^ divisor_i[DATA_W-1];
      cnt_d  = CNT_W'(DATA_W);
      rem_d  = '0;
      dvd_d  = dividend_i[DATA_W-1] ? (DATA_W'(0) - dividend_i) : dividend_i;
      dvs_d  = divisor_i[DATA_W-1] ? (DATA_W'(0) - divisor_i) : divisor_i;
    end else if (busy_q) begin
      // restore when the trial subtraction goes negative
      if (!diff[DATA_W]) begin
        rem_d = diff[DATA_W-1:0];
        dvd_d = {dvd_q[DATA_W-2:0], 1'b1};
      end else begin
        rem_d = shifted[DATA_W-1:0];
        dvd_d = {dvd_q[DATA_W-2:0], 1'b0};
      end
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    rem_q <= rem_d;
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
  end

  assign done_o = done_q;
  assign quot_o = neg_q ? (DATA_W'(0) - dvd_q) : dvd_q;

endmodule

@@ design/pl0se_ctrl.sv @@
// ----------------------------------------------------------------------------
// pl0se_ctrl
// Sequencer: steps each instruction through stack reads, writes and walks.
// ----------------------------------------------------------------------------
module pl0se_ctrl
  import pl0se_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR:    if (sts_i.clr_done) state_d = S_IDLE;
      S_IDLE:     if (in_valid_i) state_d = S_DECODE;
      S_DECODE: begin
        case (sts_i.op)
          OP_OPR: begin
            if (sts_i.opr_ret) state_d = S_RET1;
            else if (sts_i.opr_neg || sts_i.opr_odd) state_d = S_UN;
            else if (sts_i.opr_bin) state_d = S_BIN1;
            else state_d = S_DONE;
          end
          OP_LOD, OP_CAL, OP_LEA:     state_d = S_WALK;
          OP_STO:                     state_d = S_STO1;
          OP_JPC:                     state_d = S_JPC1;
          OP_LODA:                    state_d = S_LODA1;
          OP_STOA:                    state_d = S_STOA1;
          OP_ADDR_ADD, OP_ADDR_MIN:   state_d = S_AM1;
          OP_PRINT:                   state_d = S_PRT1;
          default:                    state_d = S_DONE;
        endcase
      end
      S_RET1:     state_d = S_RET2;
      S_RET2:     state_d = S_DONE;
      S_UN:       state_d = S_DONE;
      S_BIN1:     state_d = S_BIN2;
      S_BIN2:     state_d = S_BIN3;
      S_BIN3:     state_d = (sts_i.opr_div && !sts_i.c_zero) ? S_DIV_WAIT : S_BIN4;
      S_DIV_WAIT: if (sts_i.div_done) state_d = S_BIN4;
      S_BIN4:     state_d = S_DONE;
      S_STO1:     state_d = S_WALK;
      S_WALK:     state_d = sts_i.n_zero ? S_WALK_END : S_WALK_RD;
      S_WALK_RD:  state_d = sts_i.rd_in ? S_WALK : S_WALK_END;
      S_WALK_END: begin
        case (sts_i.op)
          OP_LOD:  state_d = S_LOD_W;
          OP_CAL:  state_d = S_CAL2;
          default: state_d = S_DONE;
        endcase
      end
      S_LOD_W:    state_d = S_DONE;
      S_CAL2:     state_d = S_CAL3;
      S_CAL3:     state_d = S_DONE;
      S_JPC1:     state_d = S_DONE;
      S_LODA1:    state_d = S_LODA2;
      S_LODA2:    state_d = S_DONE;
      S_STOA1:    state_d = S_STOA2;
      S_STOA2:    state_d = S_STOA3;
      S_STOA3:    state_d = S_DONE;
      S_AM1:      state_d = S_AM2;
      S_AM2:      state_d = S_AM3;
      S_AM3:      state_d = S_AM4;
      S_AM4:      state_d = S_DONE;
      S_PRT1:     state_d = S_DONE;
      S_DONE:     if (sts_i.out_free) state_d = S_IDLE;
      default:    state_d = S_CLEAR;
    endcase
  end

  always_comb begin
    cmd_o           = '0;
    cmd_o.addr_sel  = A_TOP;
    cmd_o.wdata_sel = W_ZERO;
    cmd_o.top_op    = T_HOLD;
    cmd_o.pc_op     = P_HOLD;
    cmd_o.la_op     = LA_HOLD;
    cmd_o.err_val   = ERR_RANGE;
    in_ready_o      = 1'b0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.mem_en   = 1'b1;
        cmd_o.mem_we   = 1'b1;
        cmd_o.addr_sel = A_CLR;
        cmd_o.clr_step = 1'b1;
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.instr_ld = 1'b1;
          cmd_o.pc_op    = P_INC;
        end
      end
      S_DECODE: begin
        case (sts_i.op)
          OP_LIT: begin
            cmd_o.mem_en    = 1'b1;
            cmd_o.mem_we    = 1'b1;
            cmd_o.addr_sel  = A_TOP_P1;
            cmd_o.wdata_sel = W_OPD;
            cmd_o.top_op    = T_INC;
          end
          OP_OPR: begin
            if (sts_i.opr_ret) begin
              cmd_o.mem_en   = 1'b1;
              cmd_o.addr_sel = A_BASE_P2;
              cmd_o.top_op   = T_BASE_M1;
            end else if (sts_i.opr_neg || sts_i.opr_odd || sts_i.opr_bin) begin
              cmd_o.mem_en   = 1'b1;
              cmd_o.addr_sel = A_TOP;
            end
          end
          OP_LOD, OP_CAL, OP_LEA: cmd_o.walk_init = 1'b1;
          OP_STO, OP_JPC, OP_LODA, OP_STOA, OP_ADDR_ADD, OP_ADDR_MIN, OP_PRINT: begin
            cmd_o.mem_en   = 1'b1;
            cmd_o.addr_sel = A_TOP;
          end
          OP_INT: cmd_o.top_op = T_ADD_OPD;
          OP_JMP: cmd_o.pc_op  = P_OPD;
          OP_READDR: begin
            if (sts_i.prev_load) begin
              cmd_o.mem_en    = 1'b1;
              cmd_o.mem_we    = 1'b1;
              cmd_o.addr_sel  = A_TOP;
              cmd_o.wdata_sel = W_LA;
            end else begin
              cmd_o.err_set = 1'b1;
              cmd_o.err_val = ERR_READDR;
            end
          end
          default: ;
        endcase
      end
      S_RET1: begin
        cmd_o.pc_op    = P_RD;
        cmd_o.mem_en   = 1'b1;
        cmd_o.addr_sel = A_BASE_P1;
      end
      S_RET2: cmd_o.base_ld_rd = 1'b1;
      S_UN: begin
        cmd_o.mem_en    = 1'b1;
        cmd_o.mem_we    = 1'b1;
        cmd_o.addr_sel  = A_TOP;
        cmd_o.wdata_sel = sts_i.opr_neg ? W_NEG : W_ODD;
      end
      S_BIN1, S_STOA1, S_AM1: begin
        cmd_o.ld_c     = 1'b1;
        cmd_o.mem_en   = 1'b1;
        cmd_o.addr_sel = A_TOP_M1;
      end
      S_BIN2, S_AM2: cmd_o.ld_a_rd = 1'b1;
      S_BIN3: begin
        if (sts_i.opr_div && !sts_i.c_zero) cmd_o.div_start = 1'b1;
        else cmd_o.ld_a_alu = 1'b1;
      end
      S_DIV_WAIT: cmd_o.ld_a_div = sts_i.div_done;
      S_BIN4, S_AM4: begin
        cmd_o.mem_en    = 1'b1;
        cmd_o.mem_we    = 1'b1;
        cmd_o.addr_sel  = A_TOP_M1;
        cmd_o.wdata_sel = (state_q == S_AM4) ? W_AM : W_A;
        cmd_o.top_op    = T_DEC;
        if (state_q == S_BIN4 && sts_i.opr_div && sts_i.c_zero) begin
          cmd_o.err_set = 1'b1;
          cmd_o.err_val = ERR_DIV0;
        end
      end
      S_STO1: begin
        cmd_o.ld_c      = 1'b1;
        cmd_o.walk_init = 1'b1;
      end
      S_WALK: begin
        if (!sts_i.n_zero) begin
          cmd_o.mem_en   = 1'b1;
          cmd_o.addr_sel = A_B;
        end
      end
      S_WALK_RD: begin
        if (sts_i.rd_in) cmd_o.walk_step = 1'b1;
        else cmd_o.walk_fail = 1'b1;
      end
      S_WALK_END: begin
        case (sts_i.op)
          OP_LOD: begin
            cmd_o.hit_ld_eff = 1'b1;
            if (sts_i.walk_ok) cmd_o.la_op = LA_EFF;
            if (sts_i.walk_ok && sts_i.eff_in) begin
              cmd_o.mem_en   = 1'b1;
              cmd_o.addr_sel = A_EFF;
            end else begin
              cmd_o.err_set = 1'b1;
            end
          end
          OP_STO: begin
            cmd_o.top_op = T_DEC;
            if (sts_i.walk_ok && sts_i.eff_in) begin
              cmd_o.mem_en    = 1'b1;
              cmd_o.mem_we    = 1'b1;
              cmd_o.addr_sel  = A_EFF;
              cmd_o.wdata_sel = W_C;
            end else begin
              cmd_o.err_set = 1'b1;
            end
          end
          OP_CAL: begin
            cmd_o.mem_en    = 1'b1;
            cmd_o.mem_we    = 1'b1;
            cmd_o.addr_sel  = A_TOP_P1;
            cmd_o.wdata_sel = W_B;
            cmd_o.err_set   = !sts_i.walk_ok;
          end
          default: begin
            // address push: zero and an error when a link fell outside
            cmd_o.mem_en    = 1'b1;
            cmd_o.mem_we    = 1'b1;
            cmd_o.addr_sel  = A_TOP_P1;
            cmd_o.wdata_sel = W_LEA;
            cmd_o.top_op    = T_INC;
            if (sts_i.walk_ok) cmd_o.la_op = LA_EFF;
            else cmd_o.err_set = 1'b1;
          end
        endcase
      end
      S_LOD_W: begin
        cmd_o.mem_en    = 1'b1;
        cmd_o.mem_we    = 1'b1;
        cmd_o.addr_sel  = A_TOP_P1;
        cmd_o.wdata_sel = W_RDZ;
        cmd_o.top_op    = T_INC;
      end
      S_CAL2: begin
        cmd_o.mem_en    = 1'b1;
        cmd_o.mem_we    = 1'b1;
        cmd_o.addr_sel  = A_TOP_P2;
        cmd_o.wdata_sel = W_BASE;
      end
      S_CAL3: begin
        cmd_o.mem_en       = 1'b1;
        cmd_o.mem_we       = 1'b1;
        cmd_o.addr_sel     = A_TOP_P3;
        cmd_o.wdata_sel    = W_PC;
        cmd_o.base_ld_call = 1'b1;
        cmd_o.pc_op        = P_OPD;
      end
      S_JPC1: begin
        if (sts_i.rd_zero) cmd_o.pc_op = P_OPD;
        cmd_o.top_op = T_DEC;
      end
      S_LODA1: begin
        cmd_o.la_op     = LA_RD;
        cmd_o.hit_ld_rd = 1'b1;
        if (sts_i.rd_in) begin
          cmd_o.mem_en   = 1'b1;
          cmd_o.addr_sel = A_RD;
        end
      end
      S_LODA2: begin
        cmd_o.mem_en    = 1'b1;
        cmd_o.mem_we    = 1'b1;
        cmd_o.addr_sel  = A_TOP;
        cmd_o.wdata_sel = W_RDZ;
        cmd_o.err_set   = !sts_i.hit;
      end
      S_STOA2: cmd_o.la_op = LA_RD;
      S_STOA3: begin
        cmd_o.top_op = T_DEC2;
        if (sts_i.la_in) begin
          cmd_o.mem_en    = 1'b1;
          cmd_o.mem_we    = 1'b1;
          cmd_o.addr_sel  = A_LA;
          cmd_o.wdata_sel = W_C;
        end else begin
          cmd_o.err_set = 1'b1;
        end
      end
      S_AM3:  cmd_o.ld_a_alu = 1'b1;
      S_PRT1: cmd_o.ld_c     = 1'b1;
      S_DONE: cmd_o.out_ld   = sts_i.out_free;
      default: ;
    endcase
  end

  ap_accept_decode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> state_q == S_DECODE)
    else $error("accepted request not decoded");

  ap_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.div_start |-> !sts_i.c_zero)
    else $error("divider started on a zero divisor");

  ap_walk_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_WALK && !sts_i.n_zero |-> cmd_o.mem_en && !cmd_o.mem_we)
    else $error("link walk step without a stack read");

  ap_single_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_ld |=> state_q == S_IDLE)
    else $error("result loaded outside the end of an instruction");

endmodule

@@ design/pl0se_dp.sv @@
// ----------------------------------------------------------------------------
// pl0se_dp
// Datapath: machine registers, stack RAM, ALU, divider and result register.
// ----------------------------------------------------------------------------
module pl0se_dp
  import pl0se_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  instr_t  instr_i,
  input  cmd_t    cmd_i,
  output sts_t    sts_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output result_t out_res_o
);

  localparam int PAD_W = DATA_W - STACK_AW;

  instr_t              instr_q;
  opcode_e             op;
  logic [DATA_W-1:0]   opd;
  logic [CODE_AW-1:0]  pc_q, pc_d;
  logic [STACK_AW-1:0] base_q, base_d, top_q, top_d, b_q, clr_q;
  logic [LEVEL_W-1:0]  n_q;
  logic [4:0]          prev_q;
  logic [DATA_W-1:0]   la_q, la_d, a_q, c_q;
  logic                ok_q, hit_q;
  err_e                err_q;
  logic                out_valid_q;
  result_t             out_q;

  logic [STACK_AW-1:0] mem_addr;
  logic [DATA_W-1:0]   mem_wdata, rdata;
  logic [DATA_W:0]     eff;
  logic                addr_op;
  logic [DATA_W-1:0]   mul_b, alu_res, div_q;
  logic [2*DATA_W-1:0] prod;
  logic                div_done;

  assign op      = opcode_e'(instr_q.opcode);
  assign opd     = instr_q.operand;
  assign addr_op = (op == OP_ADDR_ADD) || (op == OP_ADDR_MIN);
  assign eff     = {{(DATA_W+1-STACK_AW){1'b0}}, b_q} + {opd[DATA_W-1], opd};

  // one shared multiplier: scaled address or OPR product
  assign mul_b = addr_op ? opd : c_q;
  assign prod  = a_q * mul_b;

  always_comb begin
    if (addr_op) begin
      alu_res = prod[DATA_W-1:0];
    end else begin
      case (opd)
        OPR_ADD: alu_res = a_q + c_q;
        OPR_SUB: alu_res = a_q - c_q;
        OPR_MUL: alu_res = prod[DATA_W-1:0];
        OPR_EQ:  alu_res = {{(DATA_W-1){1'b0}}, a_q == c_q};
        OPR_NE:  alu_res = {{(DATA_W-1){1'b0}}, a_q != c_q};
        OPR_LT:  alu_res = {{(DATA_W-1){1'b0}}, $signed(a_q) <  $signed(c_q)};
        OPR_GE:  alu_res = {{(DATA_W-1){1'b0}}, $signed(a_q) >= $signed(c_q)};
        OPR_GT:  alu_res = {{(DATA_W-1){1'b0}}, $signed(a_q) >  $signed(c_q)};
        OPR_LE:  alu_res = {{(DATA_W-1){1'b0}}, $signed(a_q) <= $signed(c_q)};
        default: alu_res = a_q; // divide by zero keeps the dividend
      endcase
    end
  end

  always_comb begin
    case (cmd_i.addr_sel)
      A_TOP:     mem_addr = top_q;
      A_TOP_M1:  mem_addr = top_q - STACK_AW'(1);
      A_TOP_P1:  mem_addr = top_q + STACK_AW'(1);
      A_TOP_P2:  mem_addr = top_q + STACK_AW'(2);
      A_TOP_P3:  mem_addr = top_q + STACK_AW'(3);
      A_BASE_P1: mem_addr = base_q + STACK_AW'(1);
      A_BASE_P2: mem_addr = base_q + STACK_AW'(2);
      A_B:       mem_addr = b_q;
      A_EFF:     mem_addr = eff[STACK_AW-1:0];
      A_LA:      mem_addr = la_q[STACK_AW-1:0];
      A_RD:      mem_addr = rdata[STACK_AW-1:0];
      default:   mem_addr = clr_q;
    endcase
  end

  always_comb begin
    case (cmd_i.wdata_sel)
      W_OPD:   mem_wdata = opd;
      W_NEG:   mem_wdata = DATA_W'(0) - rdata;
      W_ODD:   mem_wdata = {{(DATA_W-1){1'b0}}, rdata[0]};
      W_RDZ:   mem_wdata = hit_q ? rdata : '0;
      W_A:     mem_wdata = a_q;
      W_AM:    mem_wdata = (op == OP_ADDR_ADD) ? (a_q + c_q) : (c_q - a_q);
      W_B:     mem_wdata = ok_q ? {{PAD_W{1'b0}}, b_q} : '0;
      W_BASE:  mem_wdata = {{PAD_W{1'b0}}, base_q};
      W_PC:    mem_wdata = {{(DATA_W-CODE_AW){1'b0}}, pc_q};
      W_LEA:   mem_wdata = ok_q ? eff[DATA_W-1:0] : '0;
      W_C:     mem_wdata = c_q;
      W_LA:    mem_wdata = la_q;
      default: mem_wdata = '0;
    endcase
  end

  pl0se_ram #(
    .WIDTH (DATA_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk_i   (clk_i),
    .en_i    (cmd_i.mem_en),
    .we_i    (cmd_i.mem_we),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (rdata)
  );

  pl0se_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (a_q),
    .divisor_i  (c_q),
    .done_o     (div_done),
    .quot_o     (div_q)
  );

  always_comb begin
    case (cmd_i.top_op)
      T_INC:     top_d = top_q + STACK_AW'(1);
      T_DEC:     top_d = top_q - STACK_AW'(1);
      T_DEC2:    top_d = top_q - STACK_AW'(2);
      T_ADD_OPD: top_d = top_q + opd[STACK_AW-1:0];
      T_BASE_M1: top_d = base_q - STACK_AW'(1);
      default:   top_d = top_q;
    endcase
    case (cmd_i.pc_op)
      P_INC:   pc_d = pc_q + CODE_AW'(1);
      P_OPD:   pc_d = opd[CODE_AW-1:0];
      P_RD:    pc_d = rdata[CODE_AW-1:0];
      default: pc_d = pc_q;
    endcase
    case (cmd_i.la_op)
      LA_EFF:  la_d = eff[DATA_W-1:0];
      LA_RD:   la_d = rdata;
      default: la_d = la_q;
    endcase
    if (cmd_i.base_ld_rd) base_d = rdata[STACK_AW-1:0];
    else if (cmd_i.base_ld_call) base_d = top_q + STACK_AW'(1);
    else base_d = base_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= '0;
      base_q      <= STACK_AW'(1);
      top_q       <= STACK_AW'(3);
      prev_q      <= PREV_NONE;
      la_q        <= '0;
      err_q       <= ERR_NONE;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pc_q   <= pc_d;
      base_q <= base_d;
      top_q  <= top_d;
      la_q   <= la_d;
      if (cmd_i.clr_step) clr_q <= clr_q + STACK_AW'(1);
      if (cmd_i.instr_ld) err_q <= ERR_NONE;
      else if (cmd_i.err_set) err_q <= cmd_i.err_val;
      if (cmd_i.out_ld) begin
        prev_q      <= {1'b0, instr_q.opcode};
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.instr_ld) instr_q <= instr_i;
    if (cmd_i.ld_c) c_q <= rdata;
    if (cmd_i.ld_a_rd) a_q <= rdata;
    else if (cmd_i.ld_a_alu) a_q <= alu_res;
    else if (cmd_i.ld_a_div) a_q <= div_q;
    if (cmd_i.walk_init) begin
      b_q  <= base_q;
      n_q  <= (instr_q.level_diff > LEVEL_W'(MAX_LEVEL)) ? LEVEL_W'(MAX_LEVEL)
                                                        : instr_q.level_diff;
      ok_q <= 1'b1;
    end else if (cmd_i.walk_step) begin
      b_q <= rdata[STACK_AW-1:0];
      n_q <= n_q - LEVEL_W'(1);
    end else if (cmd_i.walk_fail) begin
      ok_q <= 1'b0;
    end
    if (cmd_i.hit_ld_eff) hit_q <= ok_q && (eff[DATA_W:STACK_AW] == '0);
    else if (cmd_i.hit_ld_rd) hit_q <= (rdata[DATA_W-1:STACK_AW] == '0);
    if (cmd_i.out_ld) begin
      out_q.next_pc     <= pc_q;
      out_q.halted      <= (pc_q == '0);
      out_q.print_valid <= (op == OP_PRINT);
      out_q.print_value <= (op == OP_PRINT) ? c_q : '0;
      out_q.newline     <= (op == OP_NEWLINE);
      out_q.error_code  <= err_q;
    end
  end

  always_comb begin
    sts_o.op        = op;
    sts_o.opr_ret   = (opd == OPR_RET);
    sts_o.opr_neg   = (opd == OPR_NEG);
    sts_o.opr_odd   = (opd == OPR_ODD);
    sts_o.opr_bin   = (opd >= OPR_ADD) && (opd <= OPR_LE) && (opd != OPR_ODD);
    sts_o.opr_div   = (opd == OPR_DIV);
    sts_o.prev_load = (prev_q == {1'b0, OP_LOD}) || (prev_q == {1'b0, OP_LODA});
    sts_o.walk_ok   = ok_q;
    sts_o.n_zero    = (n_q == '0);
    sts_o.rd_in     = (rdata[DATA_W-1:STACK_AW] == '0);
    sts_o.rd_zero   = (rdata == '0);
    sts_o.eff_in    = (eff[DATA_W:STACK_AW] == '0);
    sts_o.la_in     = (la_q[DATA_W-1:STACK_AW] == '0);
    sts_o.hit       = hit_q;
    sts_o.c_zero    = (c_q == '0);
    sts_o.div_done  = div_done;
    sts_o.clr_done  = (clr_q == {STACK_AW{1'b1}});
    sts_o.out_free  = !out_valid_q || out_ready_i;
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;

endmodule

@@ design/pl0_stack_machine_executor_unit.sv @@
// ----------------------------------------------------------------------------
// pl0_stack_machine_executor_unit
// PL/0 p-code executor: one instruction in, one result out.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i/in_ready_o/in_req_i) takes one instruction:
// opcode, level difference and operand. Output channel
// (out_valid_o/out_ready_i/out_res_o) returns one result per instruction:
// next pc, halt flag, print data, newline flag and error code.
// Instructions execute one at a time on a single-port 1024x32 stack RAM.
// LIT, INT, JMP, NEWLINE and READDR finish in the decode state; the other
// stack operations step through further states. Link walks read one link
// per level followed (at most 32); division waits on the one-bit-per-cycle
// divider. The single RAM port serialises the stack accesses.
// The next request is taken in S_IDLE, entered from S_DONE with the result.
// After reset the stack is cleared, one word a cycle, through all 1024 words;
// pc is 0, base 1, top 3. in_ready_o stays low during that pass.
// A stalled receiver holds the result in the output register; the block
// finishes the current instruction and then waits until it is taken.
// ----------------------------------------------------------------------------
module pl0_stack_machine_executor_unit
  import pl0se_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  instr_t  in_req_i,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output result_t out_res_o
);

  cmd_t cmd;
  sts_t sts;

  pl0se_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  pl0se_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .instr_i     (in_req_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_res_o   (out_res_o)
  );

endmodule
